>>> rtl/core/brle_pkg.sv
package brle_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned COUNT_W     = 7;
    localparam int unsigned BIT_IDX_W   = 3;

    localparam logic [BIT_IDX_W-1:0] BIT_TOP    = 3'd7;
    localparam logic [BIT_IDX_W-1:0] BIT_BOTTOM = 3'd0;

    localparam logic [COUNT_W-1:0] MAX_RUN_RESET = 7'd127;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    // one input request as it arrives on the port
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_message;
    } t_in_item;

    // one emitted run code
    typedef struct packed {
        logic               run_bit;
        logic [COUNT_W-1:0] run_count;
        logic               last_for_item;
        logic               message_done;
    } t_out_item;

    // classified request passed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_message;
        logic              first;
    } t_cmd;

endpackage

>>> rtl/core/bit_run_length_encoder.sv
// Bit run-length encoder. Bytes arrive on the input channel and are scanned msb first;
// each run of equal bits leaves as one code (bit value, length minus one), cut early when
// the count reaches the max_run_count register (reset 127, written on the cfg channel;
// the user must write it only while the block is idle; the block does not enforce this).
// The first byte of a message only seeds the run from its top bit; a byte flagged
// end_of_message also flushes the open run and re-arms the encoder. A front stage
// classifies requests into a short queue (QUEUE_DEPTH entries) and the back scanner
// handles one bit per cycle while a request is queued and the output is not stalled;
// a byte that ends a message also takes a flush step. The scanner holds one code until
// it knows whether that code closes its byte, then moves it to a registered output.
module bit_run_length_encoder #(
    parameter int unsigned QUEUE_DEPTH = brle_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  brle_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output brle_pkg::t_out_item          o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [brle_pkg::COUNT_W-1:0] i_cfg_data
);

    logic           push;
    logic           push_ready;
    brle_pkg::t_cmd cmd;
    logic           head_valid;
    logic           pop;
    brle_pkg::t_cmd head;

    assign o_cfg_ready = 1'b1;

    brle_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_cmd        (cmd)
    );

    brle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_cmd        (cmd),
        .o_head_valid (head_valid),
        .i_pop        (pop),
        .o_head       (head)
    );

    brle_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

>>> rtl/core/brle_front.sv
module brle_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  brle_pkg::t_in_item i_in_data,
    output logic              o_push,
    input  logic              i_push_ready,
    output brle_pkg::t_cmd    o_cmd
);

    logic r_in_msg;
    logic n_in_msg;
    logic accept;

    assign o_in_ready = i_push_ready;
    assign accept     = i_in_valid && i_push_ready;
    assign o_push     = accept;

    // the top bit of a message's first byte seeds the run bit instead of being compared
    assign o_cmd.data_byte      = i_in_data.data_byte;
    assign o_cmd.end_of_message = i_in_data.end_of_message;
    assign o_cmd.first          = !r_in_msg;

    always_comb begin
        n_in_msg = r_in_msg;
        if (accept) begin
            n_in_msg = !i_in_data.end_of_message;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
        end else begin
            r_in_msg <= n_in_msg;
        end
    end

endmodule

>>> rtl/core/brle_queue.sv
module brle_queue #(
    parameter int unsigned DEPTH = brle_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_push_ready,
    input  brle_pkg::t_cmd i_cmd,
    output logic           o_head_valid,
    input  logic           i_pop,
    output brle_pkg::t_cmd o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    brle_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> rtl/core/brle_back.sv
module brle_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_head_valid,
    input  brle_pkg::t_cmd        i_head,
    output logic                  o_pop,
    input  logic                  i_cfg_valid,
    input  logic [brle_pkg::COUNT_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output brle_pkg::t_out_item   o_out_data
);

    logic [brle_pkg::COUNT_W-1:0]   r_max;
    logic                           r_run_bit;
    logic [brle_pkg::COUNT_W-1:0]   r_cnt;
    logic [brle_pkg::BIT_IDX_W-1:0] r_idx;
    logic                           r_flush;
    logic                           r_hold_v;
    logic                           r_hold_final;
    brle_pkg::t_out_item            r_hold;
    logic                           r_out_v;
    brle_pkg::t_out_item            r_out;

    logic                           n_run_bit;
    logic [brle_pkg::COUNT_W-1:0]   n_cnt;
    logic [brle_pkg::BIT_IDX_W-1:0] n_idx;
    logic                           n_flush;
    logic                           n_hold_v;
    logic                           n_hold_final;
    brle_pkg::t_out_item            n_hold;
    logic                           n_out_v;
    brle_pkg::t_out_item            n_out;

    logic                out_free;
    logic                step;
    logic                cur_bit;
    logic                seed;
    logic                emit;
    logic                item_final;
    logic                push;
    brle_pkg::t_out_item code;

    assign out_free = !r_out_v || i_out_ready;
    assign step     = i_head_valid && out_free;
    assign cur_bit  = i_head.data_byte[r_idx];
    assign seed     = i_head.first && (r_idx == brle_pkg::BIT_TOP) && !r_flush;

    always_comb begin
        code.run_bit       = r_run_bit;
        code.run_count     = r_cnt;
        code.last_for_item = 1'b0;
        code.message_done  = r_flush;
        if (r_flush) begin
            emit       = 1'b1;
            item_final = 1'b1;
        end else begin
            emit       = !seed && ((cur_bit != r_run_bit) || (r_cnt >= r_max));
            item_final = (r_idx == brle_pkg::BIT_BOTTOM) && !i_head.end_of_message;
        end
    end

    assign o_pop = step && item_final;
    // the held code goes out once it is known whether it closes its byte
    assign push  = out_free && r_hold_v && (r_hold_final || (step && emit));

    always_comb begin
        n_run_bit    = r_run_bit;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_flush      = r_flush;
        n_hold_v     = r_hold_v;
        n_hold_final = r_hold_final;
        n_hold       = r_hold;
        n_out_v      = r_out_v;
        n_out        = r_out;

        if (out_free) begin
            n_out_v = push;
            n_out   = r_hold;
            n_out.last_for_item = r_hold_final;
            if (push) begin
                n_hold_v = 1'b0;
            end
        end

        if (step) begin
            if (r_flush) begin
                n_run_bit = 1'b0;
                n_cnt     = '0;
                n_flush   = 1'b0;
                n_idx     = brle_pkg::BIT_TOP;
            end else begin
                if (seed) begin
                    n_run_bit = cur_bit;
                    n_cnt     = '0;
                end else if (emit) begin
                    n_run_bit = cur_bit;
                    n_cnt     = '0;
                end else begin
                    n_cnt = r_cnt + brle_pkg::COUNT_W'(1);
                end
                if (r_idx == brle_pkg::BIT_BOTTOM) begin
                    n_idx   = brle_pkg::BIT_TOP;
                    n_flush = i_head.end_of_message;
                end else begin
                    n_idx = r_idx - brle_pkg::BIT_IDX_W'(1);
                end
            end

            if (emit) begin
                n_hold_v     = 1'b1;
                n_hold       = code;
                n_hold_final = item_final;
            end else if (item_final && r_hold_v && !r_hold_final) begin
                n_hold_final = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max        <= brle_pkg::MAX_RUN_RESET;
            r_run_bit    <= 1'b0;
            r_cnt        <= '0;
            r_idx        <= brle_pkg::BIT_TOP;
            r_flush      <= 1'b0;
            r_hold_v     <= 1'b0;
            r_hold_final <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            r_run_bit    <= n_run_bit;
            r_cnt        <= n_cnt;
            r_idx        <= n_idx;
            r_flush      <= n_flush;
            r_hold_v     <= n_hold_v;
            r_hold_final <= n_hold_final;
            r_out_v      <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

>>> rtl/core/brle_checker.sv
module brle_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input brle_pkg::t_out_item o_out_data
);

    // a stalled code keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output code changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // the flushed code always closes its byte
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.message_done || o_out_data.last_for_item))
        else $error("message_done without last_for_item");

    // the queue is empty right after reset, so requests are taken at once
    a_in_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

endmodule

bind bit_run_length_encoder brle_checker u_brle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
